@@ rtl/mrid_pkg.sv @@
package mrid_pkg;

	localparam int NUM_RADIX   = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int IDX_W       = 32;

	typedef logic [8:0] radix_t;
	typedef logic [2:0] pos_t;

	localparam pos_t   CFG_IDX_DIGITS = 3'd0;
	localparam pos_t   CFG_IDX_RADIX0 = 3'd1;
	localparam pos_t   CFG_IDX_RADIX5 = 3'd6;
	localparam pos_t   DIGITS_RESET   = 3'd6;
	localparam radix_t RADIX_RESET    = 9'd2;
	localparam radix_t RADIX_MAX      = 9'd256;

	typedef struct packed {
		pos_t               count;
		logic [IDX_W-1:0]   index;
	} mrid_job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_EMIT
	} bk_state_t;

	function automatic radix_t eff_radix(input radix_t r);
		radix_t res;
		res = r;
		if (r == '0) begin
			res = 9'd1;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

endpackage

@@ rtl/mrid_front.sv @@
module mrid_front #(
	parameter int MAX_DIGITS = 6
) (
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [31:0]               linear_index,
	input  mrid_pkg::pos_t            digits_in_use,
	output logic                      push_valid,
	input  logic                      push_ready,
	output mrid_pkg::mrid_job_t       push_job
);
	import mrid_pkg::*;

	pos_t count_eff;

	always_comb begin
		count_eff = digits_in_use;
		if (digits_in_use == '0) begin
			count_eff = 3'd1;
		end else if (digits_in_use > 3'(MAX_DIGITS)) begin
			count_eff = 3'(MAX_DIGITS);
		end
	end

	assign in_ready       = push_ready;
	assign push_valid     = in_valid;
	assign push_job.count = count_eff;
	assign push_job.index = linear_index;

endmodule

@@ rtl/mrid_queue.sv @@
module mrid_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  mrid_pkg::mrid_job_t   push_job,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output mrid_pkg::mrid_job_t   pop_job
);
	import mrid_pkg::*;

	mrid_job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]      wr_ptr_q;
	logic [QPTR_W-1:0]      rd_ptr_q;
	logic [QPTR_W:0]        fill_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = (fill_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_job    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

@@ rtl/mrid_back.sv @@
module mrid_back #(
	parameter int INDEX_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	output logic                  job_ready,
	input  mrid_pkg::mrid_job_t   job,
	input  mrid_pkg::radix_t      radix [mrid_pkg::NUM_RADIX],
	output logic                  out_valid,
	input  logic                  out_ready,
	output mrid_pkg::pos_t        position,
	output logic [7:0]            digit_value,
	output logic                  last_digit,
	output logic                  out_of_range
);
	import mrid_pkg::*;

	localparam int QW = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
	localparam int CW = $clog2(QW);

	bk_state_t          state_q;
	bk_state_t          state_d;
	logic [QW-1:0]      quot_q;
	logic [7:0]         rem_q;
	logic [CW-1:0]      cnt_q;
	pos_t               pos_q;
	radix_t             r_eff;
	logic [8:0]         trial;
	logic               ge;
	logic [7:0]         rem_next;
	logic               emit;
	logic               out_valid_q;
	pos_t               position_q;
	logic [7:0]         digit_q;
	logic               last_q;
	logic               oor_q;

	assign r_eff    = eff_radix(radix[pos_q]);
	assign trial    = {rem_q, quot_q[QW-1]};
	assign ge       = (trial >= r_eff);
	assign rem_next = ge ? 8'(trial - r_eff) : trial[7:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) state_d = BK_DIV;
			end
			BK_DIV: begin
				if (cnt_q == '0) state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (emit) state_d = (pos_q == '0) ? BK_IDLE : BK_DIV;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (state_q == BK_IDLE);
		emit      = (state_q == BK_EMIT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			quot_q <= job.index[QW-1:0];
			pos_q  <= job.count - 3'd1;
			rem_q  <= '0;
			cnt_q  <= CW'(QW - 1);
		end else if (state_q == BK_DIV) begin
			quot_q <= {quot_q[QW-2:0], ge};
			rem_q  <= rem_next;
			cnt_q  <= cnt_q - 1'b1;
		end else if (emit) begin
			pos_q  <= pos_q - 3'd1;
			rem_q  <= '0;
			cnt_q  <= CW'(QW - 1);
		end
		if (emit) begin
			position_q <= pos_q;
			digit_q    <= rem_q;
			last_q     <= (pos_q == '0);
			oor_q      <= (pos_q == '0) && (quot_q != '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign position     = position_q;
	assign digit_value  = digit_q;
	assign last_digit   = last_q;
	assign out_of_range = oor_q;

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV || state_q == BK_EMIT) |-> ({1'b0, rem_q} < r_eff))
		else $error("remainder not below radix");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV || state_q == BK_EMIT) |-> (pos_q < 3'(NUM_RADIX)))
		else $error("digit position out of range");

	a_last_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (last_q == (position_q == '0)))
		else $error("last flag not tied to position zero");

	a_oor_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && oor_q) |-> last_q)
		else $error("range flag on non-final digit");

	a_emit_next_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && pos_q != '0) |=> (state_q == BK_DIV && rem_q == '0))
		else $error("next digit not started after emit");

endmodule

@@ rtl/mixed_radix_index_decompose.sv @@
// Each digit comes from a shared restoring radix-2 divider that runs one quotient bit
// a cycle over the low INDEX_BITS of the index (capped at 32 bits), then waits to emit.
// The divider starts a new index only after the last digit of the previous one is emitted.
// A two-entry queue holds accepted indexes while the divider is busy.
// Reset: arst_n clears control state; digits_in_use resets to 6, all radices to 2.
module mixed_radix_index_decompose #(
	parameter int MAX_DIGITS = 6,
	parameter int INDEX_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  mrid_pkg::pos_t        cfg_index,
	input  mrid_pkg::radix_t      cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [31:0]           linear_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mrid_pkg::pos_t        position,
	output logic [7:0]            digit_value,
	output logic                  last_digit,
	output logic                  out_of_range
);
	import mrid_pkg::*;

	pos_t       digits_q;
	radix_t     radix_q [NUM_RADIX];
	logic       push_valid;
	logic       push_ready;
	mrid_job_t  push_job;
	logic       pop_valid;
	logic       pop_ready;
	mrid_job_t  pop_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= DIGITS_RESET;
			for (int i = 0; i < NUM_RADIX; i++) begin
				radix_q[i] <= RADIX_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_IDX_DIGITS) begin
				digits_q <= cfg_data[2:0];
			end else if (cfg_index >= CFG_IDX_RADIX0 && cfg_index <= CFG_IDX_RADIX5) begin
				radix_q[cfg_index - CFG_IDX_RADIX0] <= cfg_data;
			end
		end
	end

	mrid_front #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.linear_index  (linear_index),
		.digits_in_use (digits_q),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_job      (push_job)
	);

	mrid_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	mrid_back #(
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (pop_valid),
		.job_ready    (pop_ready),
		.job          (pop_job),
		.radix        (radix_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.position     (position),
		.digit_value  (digit_value),
		.last_digit   (last_digit),
		.out_of_range (out_of_range)
	);

endmodule
